// ===== design/bc1_bc2_bc3_block_decoder_core_assert.svh =====
// assertion macros for the block decoder core
// expects clk and arst_n in the scope of the module that uses them
`ifndef BC1_BC2_BC3_BLOCK_DECODER_CORE_ASSERT_SVH
`define BC1_BC2_BC3_BLOCK_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BCDEC_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("bcdec same-cycle check failed");

// next-cycle implication, checked out of reset
`define BCDEC_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("bcdec next-cycle check failed");

`endif

// ===== design/bcdec_pkg.sv =====
// shared types, codes and arithmetic helpers of the block decoder
// no dependencies
package bcdec_pkg;

	// configuration port
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 13;
	localparam logic [CFG_IW-1:0] REG_FORMAT = 2'd0;
	localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd2;

	// block formats, the spare code decodes as interpolated alpha
	typedef enum logic [1:0] {
		FMT_DXT1 = 2'd0,
		FMT_DXT3 = 2'd1,
		FMT_DXT5 = 2'd2
	} fmt_t;

	// colour channels inside a palette entry
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// colour index that is transparent black in punch-through mode
	localparam logic [1:0] TRANSPARENT_IDX = 2'd3;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	// one decoded block as handed from front to back
	typedef struct packed {
		logic [3:0][2:0][7:0] pal;
		logic [7:0][7:0]      apal;
		fmt_t                 fmt;
		logic                 clear3;
		logic [31:0]          cidx;
		logic [63:0]          abits;
		logic [11:0]          base_x;
		logic [11:0]          base_y;
		logic [1:0]           last_col;
		logic [1:0]           last_row;
		logic                 any;
		logic                 last_block;
	} blk_t;

	typedef struct packed {
		logic           valid;
		logic           full;
		logic [QCW-1:0] count;
	} qstat_t;

	typedef struct packed {
		logic busy;
		logic live;
	} bstat_t;

	// one output pixel
	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [11:0] x;
		logic [11:0] y;
		logic        blk_end;
		logic        img_end;
	} pix_t;

	// rgb565 field widening by bit replication
	function automatic logic [7:0] expand5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// truncating divide by 3 for values up to 765
	function automatic logic [7:0] div3(input logic [9:0] v);
		logic [20:0] p;
		p = 21'(v) * 21'd683;
		return p[18:11];
	endfunction

	// truncating divide by 5 for values up to 1275
	function automatic logic [7:0] div5(input logic [10:0] v);
		logic [21:0] p;
		p = 22'(v) * 22'd1639;
		return p[20:13];
	endfunction

	// truncating divide by 7 for values up to 1785
	function automatic logic [7:0] div7(input logic [10:0] v);
		logic [22:0] p;
		p = 23'(v) * 23'd2341;
		return p[21:14];
	endfunction

endpackage

// ===== design/bcdec_front.sv =====
// front end: takes blocks, tracks block position, builds the palettes
// depends on bcdec_pkg
module bcdec_front import bcdec_pkg::*; #(
	parameter int MAX_SIDE = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [63:0]       block_low,
	input  logic [63:0]       block_high,
	input  logic [1:0]        cfg_format,
	input  logic [CFG_DW-1:0] cfg_width,
	input  logic [CFG_DW-1:0] cfg_height,
	output logic              q_push,
	output blk_t              q_data,
	input  qstat_t            q_stat
);

	localparam int SW   = $clog2(MAX_SIDE + 1);
	localparam int XW   = SW + 1;
	localparam int NBLK = (MAX_SIDE + 3) / 4;
	localparam int BCW  = ($clog2(NBLK) < 1) ? 1 : $clog2(NBLK);

	logic [BCW-1:0] col_q, row_q;
	logic [SW-1:0]  wd, ht, cx, cy, rem_x, rem_y;
	logic [XW-1:0]  bw, bh;
	logic           col_end, row_end, acc;
	logic [1:0]     lcol, lrow;
	fmt_t           fmt_eff;

	logic        valid_s1;
	logic [63:0] lo_s1, hi_s1;
	fmt_t        fmt_s1;
	logic [11:0] bx_s1, by_s1;
	logic [1:0]  lcol_s1, lrow_s1;
	logic        any_s1, lastb_s1;

	// clamp the configured size into range
	always_comb begin
		if (cfg_width == '0) begin
			wd = SW'(1);
		end else if (32'(cfg_width) > MAX_SIDE) begin
			wd = SW'(MAX_SIDE);
		end else begin
			wd = SW'(cfg_width);
		end
		if (cfg_height == '0) begin
			ht = SW'(1);
		end else if (32'(cfg_height) > MAX_SIDE) begin
			ht = SW'(MAX_SIDE);
		end else begin
			ht = SW'(cfg_height);
		end
	end

	// block counts and position tests
	assign bw      = (XW'(wd) + XW'(3)) >> 2;
	assign bh      = (XW'(ht) + XW'(3)) >> 2;
	assign col_end = (XW'(col_q) + XW'(1)) >= bw;
	assign row_end = (XW'(row_q) + XW'(1)) >= bh;
	assign cx      = SW'({col_q, 2'b00});
	assign cy      = SW'({row_q, 2'b00});
	assign rem_x   = wd - cx;
	assign rem_y   = ht - cy;
	assign lcol    = (rem_x >= SW'(4)) ? 2'd3 : 2'(rem_x - SW'(1));
	assign lrow    = (rem_y >= SW'(4)) ? 2'd3 : 2'(rem_y - SW'(1));

	// format selection
	always_comb begin
		case (cfg_format)
			FMT_DXT1: fmt_eff = FMT_DXT1;
			FMT_DXT3: fmt_eff = FMT_DXT3;
			default:  fmt_eff = FMT_DXT5;
		endcase
	end

	// handshake
	assign full   = valid_s1 && q_stat.full;
	assign acc    = push && !full;
	assign q_push = valid_s1 && !q_stat.full;

	// block position in raster order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + BCW'(1);
			end else begin
				col_q <= col_q + BCW'(1);
			end
		end
	end

	// capture stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture stage payload
	always_ff @(posedge clk) begin
		if (acc) begin
			lo_s1    <= block_low;
			hi_s1    <= block_high;
			fmt_s1   <= fmt_eff;
			bx_s1    <= 12'({col_q, 2'b00});
			by_s1    <= 12'({row_q, 2'b00});
			lcol_s1  <= lcol;
			lrow_s1  <= lrow;
			any_s1   <= (cx < wd) && (cy < ht);
			lastb_s1 <= col_end && row_end;
		end
	end

	// palette construction
	always_comb begin
		logic [63:0]      cw;
		logic [15:0]      c0, c1;
		logic [2:0][7:0]  e0, e1;
		logic             punch;
		logic [7:0]       a0, a1;

		cw    = (fmt_s1 == FMT_DXT1) ? lo_s1 : hi_s1;
		c0    = cw[15:0];
		c1    = cw[31:16];
		punch = (fmt_s1 == FMT_DXT1) && (c0 <= c1);
		e0[CH_RED]   = expand5(c0[15:11]);
		e0[CH_GREEN] = expand6(c0[10:5]);
		e0[CH_BLUE]  = expand5(c0[4:0]);
		e1[CH_RED]   = expand5(c1[15:11]);
		e1[CH_GREEN] = expand6(c1[10:5]);
		e1[CH_BLUE]  = expand5(c1[4:0]);

		q_data = '0;
		for (int ch = 0; ch < 3; ch++) begin
			q_data.pal[0][ch] = e0[ch];
			q_data.pal[1][ch] = e1[ch];
			if (punch) begin
				q_data.pal[2][ch] = 8'((9'(e0[ch]) + 9'(e1[ch])) >> 1);
				q_data.pal[3][ch] = 8'h00;
			end else begin
				q_data.pal[2][ch] = div3({1'b0, e0[ch], 1'b0} + 10'(e1[ch]));
				q_data.pal[3][ch] = div3(10'(e0[ch]) + {1'b0, e1[ch], 1'b0});
			end
		end

		// interpolated alpha levels
		a0 = lo_s1[7:0];
		a1 = lo_s1[15:8];
		q_data.apal[0] = a0;
		q_data.apal[1] = a1;
		if (a0 > a1) begin
			for (int i = 2; i < 8; i++) begin
				q_data.apal[i] = div7(11'(a0) * 11'(8 - i) + 11'(a1) * 11'(i - 1));
			end
		end else begin
			for (int i = 2; i < 6; i++) begin
				q_data.apal[i] = div5(11'(a0) * 11'(6 - i) + 11'(a1) * 11'(i - 1));
			end
			q_data.apal[6] = 8'h00;
			q_data.apal[7] = 8'hFF;
		end

		q_data.fmt        = fmt_s1;
		q_data.clear3     = punch;
		q_data.cidx       = cw[63:32];
		q_data.abits      = lo_s1;
		q_data.base_x     = bx_s1;
		q_data.base_y     = by_s1;
		q_data.last_col   = lcol_s1;
		q_data.last_row   = lrow_s1;
		q_data.any        = any_s1;
		q_data.last_block = lastb_s1;
	end

endmodule

// ===== design/bcdec_queue.sv =====
// short queue of decoded blocks between front and back
// depends on bcdec_pkg
module bcdec_queue import bcdec_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  blk_t   din,
	input  logic   pop,
	output blk_t   dout,
	output qstat_t stat
);

	blk_t           mem_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_push, do_pop;

	assign stat.valid = count_q != '0;
	assign stat.full  = count_q == QCW'(QUEUE_DEPTH);
	assign stat.count = count_q;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;
	assign dout       = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

// ===== design/bcdec_back.sv =====
// back end: walks the pixels of a block inside the image, one per cycle while the output register is free or popped
// depends on bcdec_pkg
module bcdec_back import bcdec_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  blk_t   q_data,
	output logic   q_pop,
	output logic   empty,
	input  logic   pop,
	output pix_t   pix,
	output bstat_t stat
);

	blk_t       cur_q;
	logic       busy_q, out_valid_q;
	logic [1:0] i_q, j_q;
	pix_t       pix_q, pix_d;
	logic       emit, fin, load;

	// pixel walk control
	assign emit  = busy_q && (!out_valid_q || pop);
	assign fin   = emit && (j_q == cur_q.last_col) && (i_q == cur_q.last_row);
	assign load  = q_valid && (!busy_q || fin);
	assign q_pop = load;
	assign empty = !out_valid_q;
	assign pix   = pix_q;
	assign stat.busy = busy_q;
	assign stat.live = cur_q.any;

	// pixel lookup
	always_comb begin
		logic [3:0] pi;
		logic [1:0] ci;
		logic [3:0] an;
		logic [2:0] ai;

		pi = {i_q, j_q};
		ci = cur_q.cidx[{pi, 1'b0} +: 2];
		an = cur_q.abits[{pi, 2'b00} +: 4];
		ai = cur_q.abits[6'd16 + 6'd3 * {2'b00, pi} +: 3];

		pix_d.red   = cur_q.pal[ci][CH_RED];
		pix_d.green = cur_q.pal[ci][CH_GREEN];
		pix_d.blue  = cur_q.pal[ci][CH_BLUE];
		case (cur_q.fmt)
			FMT_DXT1: pix_d.alpha = (cur_q.clear3 && ci == TRANSPARENT_IDX) ? 8'h00 : 8'hFF;
			FMT_DXT3: pix_d.alpha = {an, an};
			default:  pix_d.alpha = cur_q.apal[ai];
		endcase
		pix_d.x       = cur_q.base_x + 12'(j_q);
		pix_d.y       = cur_q.base_y + 12'(i_q);
		pix_d.blk_end = (j_q == cur_q.last_col) && (i_q == cur_q.last_row);
		pix_d.img_end = pix_d.blk_end && cur_q.last_block;
	end

	// block load and row/column counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
		end else if (load) begin
			busy_q <= q_data.any;
			i_q    <= '0;
			j_q    <= '0;
		end else begin
			if (fin) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				if (j_q == cur_q.last_col) begin
					j_q <= '0;
					i_q <= i_q + 2'd1;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_q <= pix_d;
		end
	end

endmodule

// ===== design/bc1_bc2_bc3_block_decoder_core.sv =====
// path: a block passes the capture stage, the block queue, the back end's current-block register
//   and the output register; throughput: one pixel per cycle from the back end while the output
//   is free or popped; a block gives just its pixels inside the image, or none if it has none
// the front takes a block per cycle while the 2-entry block queue has room
// reset: block position to the origin, format DXT1, image 4x4, queue and output empty
module bc1_bc2_bc3_block_decoder_core import bcdec_pkg::*; #(
	parameter int MAX_SIDE = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [63:0]       block_low,
	input  logic [63:0]       block_high,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic [7:0]        alpha,
	output logic [11:0]       pixel_x,
	output logic [11:0]       pixel_y,
	output logic              block_end,
	output logic              image_end,
	input  logic              cfg_write,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

`include "bc1_bc2_bc3_block_decoder_core_assert.svh"

	logic [1:0]        fmt_q;
	logic [CFG_DW-1:0] width_q, height_q;
	logic              q_push, q_pop;
	blk_t              q_in, q_out;
	qstat_t            q_stat;
	bstat_t            b_stat;
	pix_t              pix;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_DXT1;
			width_q  <= CFG_DW'(4);
			height_q <= CFG_DW'(4);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FORMAT: fmt_q    <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bcdec_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.block_low (block_low),
		.block_high(block_high),
		.cfg_format(fmt_q),
		.cfg_width (width_q),
		.cfg_height(height_q),
		.q_push    (q_push),
		.q_data    (q_in),
		.q_stat    (q_stat)
	);

	bcdec_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_in),
		.pop   (q_pop),
		.dout  (q_out),
		.stat  (q_stat)
	);

	bcdec_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_stat.valid),
		.q_data (q_out),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.pix    (pix),
		.stat   (b_stat)
	);

	// result ports
	assign red       = pix.red;
	assign green     = pix.green;
	assign blue      = pix.blue;
	assign alpha     = pix.alpha;
	assign pixel_x   = pix.x;
	assign pixel_y   = pix.y;
	assign block_end = pix.blk_end;
	assign image_end = pix.img_end;

	// checks
	`BCDEC_ASSERT_IMP(a_busy_has_pixels, b_stat.busy, b_stat.live)
	`BCDEC_ASSERT_IMP(a_queue_bound, 1'b1, q_stat.count <= QCW'(QUEUE_DEPTH))
	`BCDEC_ASSERT_IMP(a_image_end_on_block_end, !empty && image_end, block_end)
	`BCDEC_ASSERT_NXT(a_queue_holds_push, q_push, q_stat.valid)

endmodule
